@@ rtl/qra_pkg.sv @@
// ----------------------------------------------------------------------------
// qra_pkg
// Shared types, constants and tables of the quaternion rotation accumulator.
// ----------------------------------------------------------------------------
package qra_pkg;

  localparam int COMP_WIDTH_DEF = 16;
  localparam int IO_W           = 16;
  localparam int IO_FRAC        = 14;
  localparam int LANES          = 4;
  localparam int NPROD          = 9;

  typedef struct packed {
    logic               restart;
    logic signed [15:0] in_w;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic signed [15:0] in_z;
  } qra_in_t;

  typedef struct packed {
    logic signed [15:0] rot_r0_c0;
    logic signed [15:0] rot_r1_c0;
    logic signed [15:0] rot_r2_c0;
    logic signed [15:0] rot_r0_c1;
    logic signed [15:0] rot_r1_c1;
    logic signed [15:0] rot_r2_c1;
    logic signed [15:0] rot_r0_c2;
    logic signed [15:0] rot_r1_c2;
    logic signed [15:0] rot_r2_c2;
    logic               zero_norm;
  } qra_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_QCAP, ST_SQR, ST_SUM, ST_SQRT,
    ST_DIVLD, ST_DIV, ST_STORE, ST_MAT, ST_ENT
  } qra_state_e;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
    logic acc_neg;
    logic div_ld;
    logic div_step;
  } qra_lane_ctrl_t;

  // Hamilton product: lane i, step j uses a[j] * b[i ^ j]; set bit j = subtract
  localparam logic [3:0] MUL_NEG [LANES] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  // Matrix products over three steps: xx yy zz xy | wz xz wy yz | wx
  localparam logic [1:0] MAT_A [3][LANES] = '{
    '{2'd1, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd1, 2'd0, 2'd2},
    '{2'd0, 2'd0, 2'd0, 2'd0}};
  localparam logic [1:0] MAT_B [3][LANES] = '{
    '{2'd1, 2'd2, 2'd3, 2'd2},
    '{2'd3, 2'd3, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd0, 2'd0}};

endpackage

@@ rtl/qra_lane.sv @@
// ----------------------------------------------------------------------------
// qra_lane
// One component lane: registered multiplier, accumulator and restoring divider.
// ----------------------------------------------------------------------------
module qra_lane import qra_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qra_lane_ctrl_t                ctrl_i,
  input  logic signed [COMP_WIDTH-1:0]  op_a_i,
  input  logic signed [COMP_WIDTH-1:0]  op_b_i,
  input  logic        [COMP_WIDTH-1:0]  mag_i,
  input  logic        [COMP_WIDTH-1:0]  root_i,
  output logic signed [2*COMP_WIDTH-1:0] prod_o,
  output logic signed [2*COMP_WIDTH+1:0] acc_o,
  output logic        [COMP_WIDTH-2:0]  quot_o
);

  localparam int CW = COMP_WIDTH;
  localparam int F  = CW - 2;
  localparam int NW = 2 * CW - 1;

  logic signed [2*CW-1:0] prod_q;
  logic signed [2*CW+1:0] acc_q;
  logic        [CW-1:0]   rem_q;
  logic        [CW-2:0]   num_q;
  logic        [CW-2:0]   quot_q;
  logic        [NW-1:0]   numer;
  logic        [CW:0]     rem2;
  logic                   ge;

  assign numer = (NW'(mag_i) << F) + NW'(root_i >> 1);
  assign rem2  = {rem_q, num_q[CW-2]};
  assign ge    = rem2 >= {1'b0, root_i};

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      if (ctrl_i.acc_neg) begin
        acc_q <= acc_q - (2*CW+2)'(prod_q);
      end else begin
        acc_q <= acc_q + (2*CW+2)'(prod_q);
      end
    end
  end

  // quotient stays below 2^(F+1), so the top bits already sit under the divisor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_ld) begin
      rem_q  <= numer[NW-1:CW-1];
      num_q  <= numer[CW-2:0];
      quot_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q  <= ge ? CW'(rem2 - {1'b0, root_i}) : rem2[CW-1:0];
      num_q  <= num_q << 1;
      quot_q <= {quot_q[CW-3:0], ge};
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/qra_isqrt.sv @@
// ----------------------------------------------------------------------------
// qra_isqrt
// Digit-by-digit integer square root, one result bit per step_i cycle.
// ----------------------------------------------------------------------------
module qra_isqrt import qra_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      ld_i,
  input  logic                      step_i,
  input  logic [2*COMP_WIDTH-1:0]   sum_i,
  output logic [COMP_WIDTH-1:0]     root_o
);

  localparam int CW = COMP_WIDTH;

  logic [2*CW-1:0] s_q;
  logic [CW+1:0]   rem_q;
  logic [CW-1:0]   root_q;
  logic [CW+3:0]   rem2;
  logic [CW+3:0]   trial;
  logic            ge;

  assign rem2  = {rem_q, s_q[2*CW-1:2*CW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      s_q    <= sum_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      s_q    <= s_q << 2;
      rem_q  <= ge ? (CW+2)'(rem2 - trial) : rem2[CW+1:0];
      root_q <= {root_q[CW-2:0], ge};
    end
  end

  assign root_o = root_q;

endmodule

@@ rtl/qra_merge.sv @@
// ----------------------------------------------------------------------------
// qra_merge
// Combines the lane products into the nine saturated Q2.14 matrix entries.
// ----------------------------------------------------------------------------
module qra_merge import qra_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic signed [2*COMP_WIDTH-1:0] prod_i [NPROD],
  output logic signed [IO_W-1:0]         ent_o  [NPROD]
);

  localparam int CW  = COMP_WIDTH;
  localparam int F   = CW - 2;
  localparam int EW  = 2 * CW + 8;
  localparam int K   = 2 * F - IO_FRAC;
  localparam int RSH = (K > 0) ? K : 0;
  localparam int LSH = (K < 0) ? -K : 0;
  localparam logic signed [EW-1:0] ONE  = EW'(1) <<< (2 * F);
  localparam logic signed [EW-1:0] HALF = (EW'(1) <<< RSH) >>> 1;
  localparam logic signed [EW-1:0] SMAX = EW'(32767);
  localparam logic signed [EW-1:0] SMIN = EW'(-32768);

  logic signed [EW-1:0] p   [NPROD];
  logic signed [EW-1:0] raw [NPROD];
  logic signed [EW-1:0] sc  [NPROD];

  always_comb begin
    for (int i = 0; i < NPROD; i++) begin
      p[i] = EW'(prod_i[i]);
    end
    // products: xx yy zz xy wz xz wy yz wx
    raw[0] = ONE - ((p[1] + p[2]) <<< 1);
    raw[1] = (p[3] + p[4]) <<< 1;
    raw[2] = (p[5] - p[6]) <<< 1;
    raw[3] = (p[3] - p[4]) <<< 1;
    raw[4] = ONE - ((p[0] + p[2]) <<< 1);
    raw[5] = (p[7] + p[8]) <<< 1;
    raw[6] = (p[5] + p[6]) <<< 1;
    raw[7] = (p[7] - p[8]) <<< 1;
    raw[8] = ONE - ((p[0] + p[1]) <<< 1);
    for (int i = 0; i < NPROD; i++) begin
      sc[i] = ((raw[i] <<< LSH) + HALF) >>> RSH;
      if (sc[i] > SMAX) begin
        ent_o[i] = 16'sh7fff;
      end else if (sc[i] < SMIN) begin
        ent_o[i] = -16'sh8000;
      end else begin
        ent_o[i] = sc[i][IO_W-1:0];
      end
    end
  end

endmodule

@@ rtl/quaternion_rotation_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_rotation_accumulator_unit
// Orientation quaternion accumulator giving a saturated rotation matrix.
// ----------------------------------------------------------------------------
// Input beats (valid/ready) carry a Q2.14 quaternion and a restart bit. With
// restart the input becomes the orientation, otherwise it is multiplied on the
// left of the stored orientation. The result is normalised and stored, and one
// output beat carries the 3x3 rotation matrix (Q2.14, saturated) and the
// zero_norm flag, set when the quaternion was all zero and identity was used.
// One item is worked on at a time; in_ready_o is high only when idle.
// Acceptance to output valid is shorter on restart, which skips the multiply,
// and shorter again on a zero norm, which skips the root and the divide. The
// root, one bit per step, and the four lane dividers set most of this time.
// The output register holds a finished beat while the receiver stalls; the
// next item may be accepted and worked on meanwhile, and it waits in its last
// step until the register is free.
// Reset sets the orientation to identity and clears all handshake state.
// ----------------------------------------------------------------------------
module quaternion_rotation_accumulator_unit import qra_pkg::*; #(
  parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  qra_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output qra_out_t out_data_o
);

  localparam int CW     = COMP_WIDTH;
  localparam int F      = CW - 2;
  localparam int AW     = 2 * CW + 2;
  localparam int XW     = CW + 18;
  localparam int CNT_W  = $clog2(CW + 1);
  localparam int KIN    = IO_FRAC - F;
  localparam int RSH_IN = (KIN > 0) ? KIN : 0;
  localparam int LSH_IN = (KIN < 0) ? -KIN : 0;
  localparam logic signed [XW-1:0] HALF_IN = (XW'(1) <<< RSH_IN) >>> 1;
  localparam logic signed [XW-1:0] CMAX_X  = (XW'(1) <<< (CW - 1)) - XW'(1);
  localparam logic signed [AW:0]   HALF_Q  = (AW+1)'(1) <<< (F - 1);
  localparam logic signed [AW:0]   CMAX_A  = ((AW+1)'(1) <<< (CW - 1)) - (AW+1)'(1);
  localparam logic signed [CW-1:0] ONE_Q   = CW'(1) <<< F;

  qra_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       step;
  logic [1:0]       step_m1;

  logic signed [CW-1:0] a_q   [LANES];
  logic signed [CW-1:0] q_q   [LANES];
  logic signed [CW-1:0] ori_q [LANES];
  logic                 restart_q;
  logic                 zero_q;

  qra_lane_ctrl_t          lctrl [LANES];
  logic signed [CW-1:0]    op_a  [LANES];
  logic signed [CW-1:0]    op_b  [LANES];
  logic        [CW-1:0]    mag   [LANES];
  logic signed [2*CW-1:0]  prod  [LANES];
  logic signed [AW-1:0]    acc   [LANES];
  logic        [CW-2:0]    quot  [LANES];
  logic signed [2*CW-1:0]  mprod_q [NPROD];
  logic signed [IO_W-1:0]  ent   [NPROD];
  logic        [2*CW-1:0]  sum_sq;
  logic        [CW-1:0]    root;
  logic                    sqrt_ld, sqrt_step;
  logic                    in_acc, out_ld;
  logic signed [CW-1:0]    a_conv [LANES];
  logic signed [CW-1:0]    q_rnd  [LANES];
  logic                    out_valid_q;
  qra_out_t                out_q;

  assign step    = cnt_q[1:0];
  assign step_m1 = 2'(cnt_q - CNT_W'(1));
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // input conversion to Q2.F with symmetric saturation
  always_comb begin
    logic signed [XW-1:0] t;
    logic signed [15:0]   v [LANES];
    v[0] = in_data_i.in_w;
    v[1] = in_data_i.in_x;
    v[2] = in_data_i.in_y;
    v[3] = in_data_i.in_z;
    for (int i = 0; i < LANES; i++) begin
      t = (((XW'(v[i]) <<< LSH_IN) + HALF_IN) >>> RSH_IN);
      if (t > CMAX_X) begin
        t = CMAX_X;
      end else if (t < -CMAX_X) begin
        t = -CMAX_X;
      end
      a_conv[i] = t[CW-1:0];
    end
  end

  // product rounding, or the converted input on restart
  always_comb begin
    logic signed [AW:0] t;
    for (int i = 0; i < LANES; i++) begin
      t = ((AW+1)'(acc[i]) + HALF_Q) >>> F;
      if (t > CMAX_A) begin
        t = CMAX_A;
      end else if (t < -CMAX_A) begin
        t = -CMAX_A;
      end
      q_rnd[i] = restart_q ? a_q[i] : t[CW-1:0];
      mag[i]   = q_q[i][CW-1] ? CW'(-q_q[i]) : CW'(q_q[i]);
    end
  end

  assign sum_sq = $unsigned(prod[0]) + $unsigned(prod[1])
                + $unsigned(prod[2]) + $unsigned(prod[3]);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    sqrt_ld   = 1'b0;
    sqrt_step = 1'b0;
    out_ld    = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      lctrl[i] = '0;
      op_a[i]  = q_q[i];
      op_b[i]  = q_q[i];
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          for (int i = 0; i < LANES; i++) lctrl[i].acc_clr = 1'b1;
          state_d = in_data_i.restart ? ST_QCAP : ST_MUL;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        for (int i = 0; i < LANES; i++) begin
          op_a[i] = a_q[step];
          op_b[i] = ori_q[2'(i) ^ step];
          lctrl[i].acc_en  = (cnt_q != '0);
          lctrl[i].acc_neg = MUL_NEG[i][step_m1];
        end
        if (cnt_q == CNT_W'(LANES)) begin
          state_d = ST_QCAP;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_QCAP:  state_d = ST_SQR;
      ST_SQR:   state_d = ST_SUM;
      ST_SUM: begin
        cnt_d = '0;
        if (sum_sq == '0) begin
          state_d = ST_MAT;
        end else begin
          sqrt_ld = 1'b1;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sqrt_step = 1'b1;
        if (cnt_q == CNT_W'(CW - 1)) begin
          state_d = ST_DIVLD;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIVLD: begin
        for (int i = 0; i < LANES; i++) lctrl[i].div_ld = 1'b1;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        for (int i = 0; i < LANES; i++) lctrl[i].div_step = 1'b1;
        if (cnt_q == CNT_W'(CW - 2)) begin
          state_d = ST_STORE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_STORE: begin
        cnt_d   = '0;
        state_d = ST_MAT;
      end
      ST_MAT: begin
        for (int i = 0; i < LANES; i++) begin
          op_a[i] = ori_q[MAT_A[(step < 2'd3) ? step : 2'd0][i]];
          op_b[i] = ori_q[MAT_B[(step < 2'd3) ? step : 2'd0][i]];
        end
        if (cnt_q == CNT_W'(3)) begin
          state_d = ST_ENT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_ENT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ori_q[0] <= ONE_Q;
      ori_q[1] <= '0;
      ori_q[2] <= '0;
      ori_q[3] <= '0;
    end else if (state_q == ST_SUM && sum_sq == '0) begin
      ori_q[0] <= ONE_Q;
      ori_q[1] <= '0;
      ori_q[2] <= '0;
      ori_q[3] <= '0;
    end else if (state_q == ST_STORE) begin
      for (int i = 0; i < LANES; i++) begin
        ori_q[i] <= q_q[i][CW-1] ? -CW'(quot[i]) : CW'(quot[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      restart_q <= in_data_i.restart;
      for (int i = 0; i < LANES; i++) a_q[i] <= a_conv[i];
    end
    if (state_q == ST_QCAP) begin
      for (int i = 0; i < LANES; i++) q_q[i] <= q_rnd[i];
    end
    if (state_q == ST_SUM) begin
      zero_q <= (sum_sq == '0);
    end
    if (state_q == ST_MAT && cnt_q != '0) begin
      unique case (step_m1)
        2'd0: for (int i = 0; i < LANES; i++) mprod_q[i] <= prod[i];
        2'd1: for (int i = 0; i < LANES; i++) mprod_q[LANES + i] <= prod[i];
        default: mprod_q[2 * LANES] <= prod[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_q.rot_r0_c0 <= ent[0];
      out_q.rot_r1_c0 <= ent[1];
      out_q.rot_r2_c0 <= ent[2];
      out_q.rot_r0_c1 <= ent[3];
      out_q.rot_r1_c1 <= ent[4];
      out_q.rot_r2_c1 <= ent[5];
      out_q.rot_r0_c2 <= ent[6];
      out_q.rot_r1_c2 <= ent[7];
      out_q.rot_r2_c2 <= ent[8];
      out_q.zero_norm <= zero_q;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    qra_lane #(.COMP_WIDTH(CW)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lctrl[g]),
      .op_a_i (op_a[g]),
      .op_b_i (op_b[g]),
      .mag_i  (mag[g]),
      .root_i (root),
      .prod_o (prod[g]),
      .acc_o  (acc[g]),
      .quot_o (quot[g])
    );
  end

  qra_isqrt #(.COMP_WIDTH(CW)) u_isqrt (
    .clk_i  (clk_i),
    .ld_i   (sqrt_ld),
    .step_i (sqrt_step),
    .sum_i  (sum_sq),
    .root_o (root)
  );

  qra_merge #(.COMP_WIDTH(CW)) u_merge (
    .prod_i (mprod_q),
    .ent_o  (ent)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/qra_checker.sv @@
// ----------------------------------------------------------------------------
// qra_checker
// Port-level checks of the rotation accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module qra_checker import qra_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input qra_out_t out_data_o
);

  // one item in work at a time: no beat right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

  // zero norm reports identity: diagonal, rot_r0_c1, rot_r1_c0 and rot_r2_c0
  a_zero_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_norm |->
      out_data_o.rot_r0_c0 == 16'sd16384 && out_data_o.rot_r1_c1 == 16'sd16384 &&
      out_data_o.rot_r2_c2 == 16'sd16384 && out_data_o.rot_r0_c1 == 16'sd0 &&
      out_data_o.rot_r1_c0 == 16'sd0 && out_data_o.rot_r2_c0 == 16'sd0)
    else $error("zero norm without identity matrix");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

endmodule

bind quaternion_rotation_accumulator_unit qra_checker u_qra_checker (.*);
